// File: rtl/core/hh4_pkg.sv
package hh4_pkg;

  // Largest accepted frame: type byte + header + payload
  localparam int unsigned MAX_FRAME = 1024;
  localparam int unsigned TOTAL_W = 17;

  // Command queue between parser and result sequencer
  localparam int unsigned CMDQ_DEPTH = 8;
  localparam int unsigned CMDQ_AW = $clog2(CMDQ_DEPTH);

  // Configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;
  localparam logic [1:0] REG_ISO_EN = 2'd0;
  localparam logic [1:0] REG_CLASSIC_EN = 2'd1;
  localparam logic [1:0] REG_EXT_ADV_EN = 2'd2;

  // H4 packet type codes
  localparam logic [2:0] TY_CMD = 3'd1;
  localparam logic [2:0] TY_ACL = 3'd2;
  localparam logic [2:0] TY_SCO = 3'd3;
  localparam logic [2:0] TY_EVT = 3'd4;
  localparam logic [2:0] TY_ISO = 3'd5;

  // Result packet kinds
  localparam logic [1:0] KIND_EVT = 2'd0;
  localparam logic [1:0] KIND_ACL = 2'd1;
  localparam logic [1:0] KIND_ISO = 2'd2;

  // Event codes of interest
  localparam logic [7:0] EVT_INQ_RESULT_RSSI = 8'h22;
  localparam logic [7:0] EVT_EXT_INQ_RESULT = 8'h2F;
  localparam logic [7:0] EVT_LE_META = 8'h3E;
  localparam logic [7:0] SUB_ADV_REPORT = 8'h02;
  localparam logic [7:0] SUB_EXT_ADV_REPORT = 8'h0D;
  localparam logic [7:0] ADV_TYPE_LEGACY = 8'h10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_BAD_TYPE,
    ST_OVERSIZE
  } status_e;

  // One queued command: a run of one to four results
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            first;
    logic            last;
    logic            disc;
    logic [1:0]      kind;
    status_e         status;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       first;
    logic       last;
    logic       disc;
    status_e    status;
  } res_t;

  function automatic logic [2:0] hdr_len(input logic [2:0] ty);
    logic [2:0] len;
    case (ty)
      TY_CMD, TY_SCO: len = 3'd3;
      TY_EVT: len = 3'd2;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] kind_of(input logic [2:0] ty);
    logic [1:0] k;
    case (ty)
      TY_ACL: k = KIND_ACL;
      TY_ISO: k = KIND_ISO;
      default: k = KIND_EVT;
    endcase
    return k;
  endfunction

  function automatic logic evt_disc(input logic [7:0] code, input logic [7:0] sub,
                                    input logic [7:0] cnt, input logic [7:0] rtype,
                                    input logic classic_en, input logic ext_adv_en);
    logic d;
    d = 1'b0;
    if (classic_en && (code == EVT_INQ_RESULT_RSSI || code == EVT_EXT_INQ_RESULT)) begin
      d = 1'b1;
    end
    if (code == EVT_LE_META) begin
      if (sub == SUB_ADV_REPORT) begin
        d = 1'b1;
      end
      if (ext_adv_en && sub == SUB_EXT_ADV_REPORT && cnt == 8'd1 &&
          (rtype & ADV_TYPE_LEGACY) != 8'd0) begin
        d = 1'b1;
      end
    end
    return d;
  endfunction

endpackage

// File: rtl/core/hh4_front.sv
module hh4_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          iso_en_i,
  input  logic          classic_en_i,
  input  logic          ext_adv_en_i,
  output logic          push_o,
  output hh4_pkg::cmd_t cmd_o
);

  hh4_pkg::phase_e  phase_q, phase_d;
  logic [2:0]       type_q, type_d;
  logic [3:0][7:0]  hdr_q, hdr_d;
  logic [2:0]       hc_q, hc_d;
  logic [15:0]      rem_q, rem_d;
  logic [1:0]       pidx_q, pidx_d;
  logic [7:0]       code_q, code_d;
  logic [7:0]       sub_q, sub_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       rtype_q, rtype_d;
  logic             skip_q, skip_d;

  logic [2:0]       hl;
  logic [2:0]       hc_inc;
  logic [3:0][7:0]  hdr_new;
  logic [15:0]      plen;
  logic [hh4_pkg::TOTAL_W-1:0] total;
  logic [15:0]      rem_dec;
  logic             type_ok;

  always_comb begin
    hl = hh4_pkg::hdr_len(type_q);
    hc_inc = hc_q + 3'd1;
    hdr_new = hdr_q;
    hdr_new[hc_q[1:0]] = rx_byte_i;
    case (type_q)
      hh4_pkg::TY_EVT: plen = {8'd0, hdr_new[1]};
      hh4_pkg::TY_CMD, hh4_pkg::TY_SCO: plen = {8'd0, hdr_new[2]};
      hh4_pkg::TY_ISO: plen = {2'b00, hdr_new[3][5:0], hdr_new[2]};
      default: plen = {hdr_new[3], hdr_new[2]};
    endcase
    total = hh4_pkg::TOTAL_W'(1) + hh4_pkg::TOTAL_W'(hl) + hh4_pkg::TOTAL_W'(plen);
    rem_dec = rem_q - 16'd1;
    type_ok = (rx_byte_i >= {5'd0, hh4_pkg::TY_CMD}) && (rx_byte_i <= {5'd0, hh4_pkg::TY_ISO}) &&
              !(rx_byte_i == {5'd0, hh4_pkg::TY_ISO} && !iso_en_i);
  end

  always_comb begin
    phase_d = phase_q;
    type_d = type_q;
    hdr_d = hdr_q;
    hc_d = hc_q;
    rem_d = rem_q;
    pidx_d = pidx_q;
    code_d = code_q;
    sub_d = sub_q;
    cnt_d = cnt_q;
    rtype_d = rtype_q;
    skip_d = skip_q;
    push_o = 1'b0;
    cmd_o = '0;

    if (accept_i) begin
      case (phase_q)
        hh4_pkg::PH_IDLE: begin
          if (type_ok) begin
            type_d = rx_byte_i[2:0];
            hc_d = 3'd0;
            skip_d = 1'b0;
            phase_d = hh4_pkg::PH_HEADER;
          end else begin
            // Report the offending type byte, stay on type parsing
            push_o = 1'b1;
            cmd_o.bytes[0] = rx_byte_i;
            cmd_o.status = hh4_pkg::ST_BAD_TYPE;
          end
        end
        hh4_pkg::PH_HEADER: begin
          hdr_d = hdr_new;
          hc_d = hc_inc;
          if (hc_inc >= hl) begin
            code_d = hdr_new[0];
            sub_d = 8'd0;
            cnt_d = 8'd0;
            rtype_d = 8'd0;
            pidx_d = 2'd0;
            rem_d = plen;
            if (total > hh4_pkg::TOTAL_W'(hh4_pkg::MAX_FRAME)) begin
              push_o = 1'b1;
              cmd_o.status = hh4_pkg::ST_OVERSIZE;
              skip_d = 1'b1;
            end else if (type_q == hh4_pkg::TY_CMD || type_q == hh4_pkg::TY_SCO) begin
              skip_d = 1'b1;
            end else begin
              // Release the whole header as one command
              push_o = 1'b1;
              skip_d = 1'b0;
              cmd_o.bytes = hdr_new;
              cmd_o.last_idx = 2'(hl - 3'd1);
              cmd_o.first = 1'b1;
              cmd_o.last = (plen == 16'd0);
              cmd_o.kind = hh4_pkg::kind_of(type_q);
              cmd_o.disc = (plen == 16'd0) && (type_q == hh4_pkg::TY_EVT) &&
                           hh4_pkg::evt_disc(hdr_new[0], 8'd0, 8'd0, 8'd0,
                                             classic_en_i, ext_adv_en_i);
              cmd_o.status = hh4_pkg::ST_DATA;
            end
            if (plen == 16'd0) begin
              phase_d = hh4_pkg::PH_IDLE;
              skip_d = 1'b0;
              rem_d = 16'd0;
            end else begin
              phase_d = hh4_pkg::PH_PAYLOAD;
            end
          end
        end
        hh4_pkg::PH_PAYLOAD: begin
          rem_d = rem_dec;
          if (!skip_q) begin
            if (type_q == hh4_pkg::TY_EVT) begin
              case (pidx_q)
                2'd0: sub_d = rx_byte_i;
                2'd1: cnt_d = rx_byte_i;
                2'd2: rtype_d = rx_byte_i;
                default: ;
              endcase
              if (pidx_q != 2'd3) begin
                pidx_d = pidx_q + 2'd1;
              end
            end
            push_o = 1'b1;
            cmd_o.bytes[0] = rx_byte_i;
            cmd_o.last = (rem_dec == 16'd0);
            cmd_o.kind = hh4_pkg::kind_of(type_q);
            cmd_o.disc = (rem_dec == 16'd0) && (type_q == hh4_pkg::TY_EVT) &&
                         hh4_pkg::evt_disc(code_q, sub_d, cnt_d, rtype_d,
                                           classic_en_i, ext_adv_en_i);
            cmd_o.status = hh4_pkg::ST_DATA;
          end
          if (rem_dec == 16'd0) begin
            phase_d = hh4_pkg::PH_IDLE;
            skip_d = 1'b0;
          end
        end
        default: phase_d = hh4_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hh4_pkg::PH_IDLE;
      type_q <= 3'd0;
      hc_q <= 3'd0;
      rem_q <= 16'd0;
      pidx_q <= 2'd0;
      code_q <= 8'd0;
      sub_q <= 8'd0;
      cnt_q <= 8'd0;
      rtype_q <= 8'd0;
      skip_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      type_q <= type_d;
      hc_q <= hc_d;
      rem_q <= rem_d;
      pidx_q <= pidx_d;
      code_q <= code_d;
      sub_q <= sub_d;
      cnt_q <= cnt_d;
      rtype_q <= rtype_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

// File: rtl/core/hh4_cmdq.sv
module hh4_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hh4_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output hh4_pkg::cmd_t rdata_o,
  output logic          not_empty_o,
  output logic          full_o
);

  hh4_pkg::cmd_t              mem_q [hh4_pkg::CMDQ_DEPTH];
  logic [hh4_pkg::CMDQ_AW-1:0] wr_q, wr_d;
  logic [hh4_pkg::CMDQ_AW-1:0] rd_q, rd_d;
  logic [hh4_pkg::CMDQ_AW:0]   cnt_q, cnt_d;
  logic                        do_push, do_pop;

  always_comb begin
    do_push = push_i && !full_o;
    do_pop = pop_i && not_empty_o;
    wr_d = do_push ? wr_q + 1'b1 : wr_q;
    rd_d = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign not_empty_o = (cnt_q != '0);
  assign full_o = (cnt_q == (hh4_pkg::CMDQ_AW + 1)'(hh4_pkg::CMDQ_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/hh4_back.sv
module hh4_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hh4_pkg::cmd_t cmd_i,
  input  logic          cmd_avail_i,
  output logic          cmd_take_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hh4_pkg::res_t res_o
);

  hh4_pkg::cmd_t cur_q, cur_d;
  logic [1:0]    idx_q, idx_d;
  logic          valid_q, valid_d;
  logic          at_end;
  logic          take;

  always_comb begin
    at_end = (idx_q == cur_q.last_idx);
    take = valid_q && pop_i;
    cur_d = cur_q;
    idx_d = idx_q;
    valid_d = valid_q;
    cmd_take_o = 1'b0;
    if (!valid_q || (take && at_end)) begin
      // Load the next command as soon as the current one is drained
      cmd_take_o = cmd_avail_i;
      valid_d = cmd_avail_i;
      cur_d = cmd_i;
      idx_d = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_comb begin
    res_o.data = cur_q.bytes[idx_q];
    res_o.kind = cur_q.kind;
    res_o.first = cur_q.first && (idx_q == 2'd0);
    res_o.last = cur_q.last && at_end;
    res_o.disc = cur_q.disc && at_end;
    res_o.status = cur_q.status;
  end

  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// File: rtl/core/hci_h4_stream_deframer.sv
// H4 stream deframer for Bluetooth HCI traffic.
// Input channel: one stream byte per item on rx_byte_i, written with push
// while full is low. Result channel: a queue read with pop while empty is
// low; each result item carries a forwarded byte with packet kind, first and
// last marks, a discardable hint on an event's last byte, and a status
// (data, bad type, oversize packet).
// The parser takes one byte every cycle while full is low. Each byte that
// produces results becomes one command in an eight-entry command queue; the
// sequencer behind it emits one result item per cycle while pop is high, so a
// released header (up to four items) drains while parsing goes on.
// A result passes through the command queue and then the sequencer register
// before it reaches the result ports. Throughput: one byte per cycle sustained
// while pop stays high; the header bytes that arrive before a release give the
// sequencer its catch-up time.
// When pop stays low, results wait in the sequencer and command queue; full
// rises once the queue holds eight commands, and bytes that make no result
// still need a free queue slot to be taken.
// Reset empties both queues, puts the parser on type-byte parsing and sets
// iso_enable to 1, classic_enable and ext_adv_enable to 0.
// Configuration: APB port, register i at byte address 4*i; pready is high.
module hci_h4_stream_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  rx_byte_i,
  // result output
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  data_byte_o,
  output logic [1:0]                  packet_kind_o,
  output logic                        first_byte_o,
  output logic                        last_byte_o,
  output logic                        discardable_o,
  output logic [1:0]                  status_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hh4_pkg::APB_AW-1:0]  paddr,
  input  logic [hh4_pkg::APB_DW-1:0]  pwdata,
  output logic [hh4_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic          iso_en_q, classic_en_q, ext_adv_en_q;
  logic          cfg_wr;
  logic [1:0]    reg_idx;
  logic          accept;
  logic          front_push;
  hh4_pkg::cmd_t front_cmd;
  hh4_pkg::cmd_t q_cmd;
  logic          q_not_empty;
  logic          q_full;
  logic          q_take;
  logic          res_valid;
  hh4_pkg::res_t res;

  // Configuration registers
  assign pready = 1'b1;
  assign reg_idx = paddr[hh4_pkg::APB_AW-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      hh4_pkg::REG_ISO_EN: prdata = {{(hh4_pkg::APB_DW-1){1'b0}}, iso_en_q};
      hh4_pkg::REG_CLASSIC_EN: prdata = {{(hh4_pkg::APB_DW-1){1'b0}}, classic_en_q};
      hh4_pkg::REG_EXT_ADV_EN: prdata = {{(hh4_pkg::APB_DW-1){1'b0}}, ext_adv_en_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_en_q <= 1'b1;
      classic_en_q <= 1'b0;
      ext_adv_en_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        hh4_pkg::REG_ISO_EN: iso_en_q <= pwdata[0];
        hh4_pkg::REG_CLASSIC_EN: classic_en_q <= pwdata[0];
        hh4_pkg::REG_EXT_ADV_EN: ext_adv_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Hold off input only when the command queue has no room
  assign full = q_full;
  assign accept = push && !q_full;

  hh4_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .iso_en_i     (iso_en_q),
    .classic_en_i (classic_en_q),
    .ext_adv_en_i (ext_adv_en_q),
    .push_o       (front_push),
    .cmd_o        (front_cmd)
  );

  hh4_cmdq u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .wdata_i     (front_cmd),
    .pop_i       (q_take),
    .rdata_o     (q_cmd),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  hh4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_avail_i (q_not_empty),
    .cmd_take_o  (q_take),
    .pop_i       (pop),
    .valid_o     (res_valid),
    .res_o       (res)
  );

  assign empty = !res_valid;
  assign data_byte_o = res.data;
  assign packet_kind_o = res.kind;
  assign first_byte_o = res.first;
  assign last_byte_o = res.last;
  assign discardable_o = res.disc;
  assign status_o = res.status;

  // A queued command reaches the result side in the next cycle
  a_no_stuck_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && q_not_empty) |=> !empty)
    else $error("queued command not loaded into result stage");

  // Error results carry no packet marks
  a_err_no_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res.status != hh4_pkg::ST_DATA) |-> (!res.first && !res.last && !res.disc))
    else $error("error result carries packet marks");

  // Discardable only on the last byte of an event
  a_disc_on_evt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res.disc) |-> (res.last && res.kind == hh4_pkg::KIND_EVT))
    else $error("discardable outside an event's last byte");

endmodule

// File: test/hci_h4_stream_deframer_tb.sv
`timescale 1ns / 100ps
module hci_h4_stream_deframer_tb;

  // Run bounds: drain and settle allowances, random-phase sizes and hold-off length
  localparam int unsigned DRAIN_LIMIT = 50000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned BYTES_PER_PHASE = 25;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Longest payload that still fits in a frame with a four-byte header
  localparam int unsigned MAX_FIT_4HDR = hh4_pkg::MAX_FRAME - 5;

  typedef enum int {
    POP_FREE,
    POP_HALF,
    POP_SPARSE
  } pop_mode_e;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         push = 1'b0;
  logic [7:0]                   rx_byte = 8'h00;
  logic                         pop = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [hh4_pkg::APB_AW-1:0]   paddr = '0;
  logic [hh4_pkg::APB_DW-1:0]   pwdata = '0;
  logic                         full;
  logic                         empty;
  logic [7:0]                   data_byte;
  logic [1:0]                   packet_kind;
  logic                         first_byte;
  logic                         last_byte;
  logic                         discardable;
  logic [1:0]                   status;
  logic [hh4_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  hci_h4_stream_deframer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte),
    .empty         (empty),
    .pop           (pop),
    .data_byte_o   (data_byte),
    .packet_kind_o (packet_kind),
    .first_byte_o  (first_byte),
    .last_byte_o   (last_byte),
    .discardable_o (discardable),
    .status_o      (status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result items the deframer owes us, oldest first
  hh4_pkg::res_t h4_out_q[$];

  int unsigned errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_results = 0;
  int unsigned n_bad_type = 0;
  int unsigned n_oversize = 0;
  int unsigned n_droppable = 0;
  int unsigned n_full_stalls = 0;
  int unsigned n_settings = 0;

  // Register mirror, reset values per the block's header
  logic iso_en_m = 1'b1;
  logic classic_en_m = 1'b0;
  logic ext_adv_en_m = 1'b0;

  // Parser mirror
  hh4_pkg::phase_e ph = hh4_pkg::PH_IDLE;
  logic [2:0]  cur_ty = '0;
  logic [7:0]  hdr [4];
  int unsigned hcnt = 0;
  logic [15:0] remain = '0;
  int unsigned pidx = 0;
  logic [7:0]  ev_code = '0;
  logic [7:0]  ev_sub = '0;
  logic [7:0]  ev_cnt = '0;
  logic [7:0]  ev_rtype = '0;
  logic        skip_pkt = 1'b0;

  // Sender state: burst accounting and the mirror of push
  int unsigned burst_left = 0;
  bit          push_on = 1'b0;
  realtime     drop_t = -1.0;

  // Receiver state: a long hold-off request and the current stall mode
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  pop_mode_e   pop_mode = POP_FREE;
  int unsigned mode_left = 0;

  // ---------------------------------------------------------------------------
  // Deframing prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned hdr_bytes(input logic [2:0] ty);
    if (ty == hh4_pkg::TY_CMD || ty == hh4_pkg::TY_SCO) return 3;
    if (ty == hh4_pkg::TY_EVT) return 2;
    return 4;
  endfunction

  function automatic logic [1:0] kind_for(input logic [2:0] ty);
    if (ty == hh4_pkg::TY_ACL) return hh4_pkg::KIND_ACL;
    if (ty == hh4_pkg::TY_ISO) return hh4_pkg::KIND_ISO;
    return hh4_pkg::KIND_EVT;
  endfunction

  // Advertising reports and, when enabled, inquiry results and single legacy extended reports may be dropped
  function automatic logic evt_droppable();
    if (cur_ty != hh4_pkg::TY_EVT) return 1'b0;
    if (classic_en_m && (ev_code == hh4_pkg::EVT_INQ_RESULT_RSSI ||
                         ev_code == hh4_pkg::EVT_EXT_INQ_RESULT))
      return 1'b1;
    if (ev_code == hh4_pkg::EVT_LE_META) begin
      if (ev_sub == hh4_pkg::SUB_ADV_REPORT) return 1'b1;
      if (ext_adv_en_m && ev_sub == hh4_pkg::SUB_EXT_ADV_REPORT && ev_cnt == 8'd1 &&
          (ev_rtype & hh4_pkg::ADV_TYPE_LEGACY) != 8'd0)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic expect_item(input logic [7:0] d, input logic [1:0] k, input logic f,
                             input logic l, input logic dc, input hh4_pkg::status_e st);
    hh4_pkg::res_t r;
    r.data = d;
    r.kind = k;
    r.first = f;
    r.last = l;
    r.disc = dc;
    r.status = st;
    h4_out_q.push_back(r);
    if (st == hh4_pkg::ST_BAD_TYPE) n_bad_type++;
    if (st == hh4_pkg::ST_OVERSIZE) n_oversize++;
    if (dc) n_droppable++;
  endtask

  task automatic go_idle();
    ph = hh4_pkg::PH_IDLE;
    skip_pkt = 1'b0;
    remain = '0;
  endtask

  // Advance the parser mirror by one accepted stream byte
  task automatic deframe_byte(input logic [7:0] b);
    int unsigned hl;
    int unsigned plen;
    logic        lst;
    logic        dc;
    case (ph)
      hh4_pkg::PH_HEADER: begin
        hl = hdr_bytes(cur_ty);
        hdr[hcnt] = b;
        hcnt++;
        if (hcnt < hl) return;
        if (cur_ty == hh4_pkg::TY_EVT) plen = hdr[1];
        else if (cur_ty == hh4_pkg::TY_CMD || cur_ty == hh4_pkg::TY_SCO) plen = hdr[2];
        else plen = {hdr[3], hdr[2]};
        if (cur_ty == hh4_pkg::TY_ISO) plen = plen & 32'h3FFF;
        ev_code = hdr[0];
        ev_sub = '0;
        ev_cnt = '0;
        ev_rtype = '0;
        pidx = 0;
        remain = plen[15:0];
        if (1 + hl + plen > hh4_pkg::MAX_FRAME) begin
          expect_item(8'h00, hh4_pkg::KIND_EVT, 1'b0, 1'b0, 1'b0, hh4_pkg::ST_OVERSIZE);
          skip_pkt = 1'b1;
        end else if (cur_ty == hh4_pkg::TY_CMD || cur_ty == hh4_pkg::TY_SCO) begin
          skip_pkt = 1'b1;
        end else begin
          skip_pkt = 1'b0;
          // Release the whole header at once; an empty payload ends on it
          for (int unsigned i = 0; i < hl; i++) begin
            lst = (plen == 0) && (i + 1 == hl);
            dc = lst ? evt_droppable() : 1'b0;
            expect_item(hdr[i], kind_for(cur_ty), i == 0, lst, dc, hh4_pkg::ST_DATA);
          end
        end
        if (plen == 0) go_idle();
        else ph = hh4_pkg::PH_PAYLOAD;
      end
      hh4_pkg::PH_PAYLOAD: begin
        remain = remain - 16'd1;
        if (!skip_pkt) begin
          lst = (remain == 16'd0);
          dc = 1'b0;
          if (cur_ty == hh4_pkg::TY_EVT) begin
            // Track the leading payload bytes that classify an LE meta event
            case (pidx)
              0: ev_sub = b;
              1: ev_cnt = b;
              2: ev_rtype = b;
              default: ;
            endcase
            if (pidx < 3) pidx++;
            if (lst) dc = evt_droppable();
          end
          expect_item(b, kind_for(cur_ty), 1'b0, lst, dc, hh4_pkg::ST_DATA);
        end
        if (remain == 16'd0) go_idle();
      end
      default: begin
        if (b >= hh4_pkg::TY_CMD && b <= hh4_pkg::TY_ISO &&
            !(b == hh4_pkg::TY_ISO && !iso_en_m)) begin
          cur_ty = b[2:0];
          hcnt = 0;
          skip_pkt = 1'b0;
          ph = hh4_pkg::PH_HEADER;
        end else begin
          expect_item(b, hh4_pkg::KIND_EVT, 1'b0, 1'b0, 1'b0, hh4_pkg::ST_BAD_TYPE);
          ph = hh4_pkg::PH_IDLE;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  // Pick a stall mode for a random stretch; a hold-off request overrides it
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (mode_left == 0) begin
      pop_mode = pop_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(16, 80);
    end
    mode_left--;
    if (!rst_n || hold_left > 0) begin
      if (hold_left > 0) hold_left--;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        POP_FREE: pop <= 1'b1;
        POP_HALF: pop <= 1'($urandom_range(0, 1));
        default:  pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each popped result item with the oldest one owed
  always @(posedge clk) begin
    hh4_pkg::res_t e;
    if (rst_n && pop && !empty) begin
      n_results++;
      if (h4_out_q.size() == 0) begin
        $error("result item with none expected: data_byte %0h status %0d",
               data_byte, status);
        errors++;
      end else begin
        e = h4_out_q.pop_front();
        check_field("data_byte", e.data, data_byte);
        check_field("packet_kind", 8'(e.kind), 8'(packet_kind));
        check_field("first_byte", 8'(e.first), 8'(first_byte));
        check_field("last_byte", 8'(e.last), 8'(last_byte));
        check_field("discardable", 8'(e.disc), 8'(discardable));
        check_field("status", 8'(e.status), 8'(status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream side
  // ---------------------------------------------------------------------------

  task automatic push_off();
    if (push_on) begin
      push <= 1'b0;
      push_on = 1'b0;
      drop_t = $realtime;
    end
  endtask

  // Offer one byte, honoring bursts and gaps; predict once it is taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push_off();
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    // Never drop and raise push within one time step
    if (!push_on && drop_t == $realtime) @(posedge clk);
    push <= 1'b1;
    rx_byte <= b;
    push_on = 1'b1;
    do begin
      @(posedge clk);
      if (full) n_full_stalls++;
    end while (full);
    deframe_byte(b);
    n_bytes++;
  endtask

  // Send one H4 packet; the payload starts with up to three given bytes
  task automatic send_packet(input logic [2:0] ty, input logic [15:0] len_field,
                             input logic [7:0] code, input logic [23:0] lead,
                             input int unsigned n_lead);
    int unsigned count;
    if (ty == hh4_pkg::TY_ISO) count = len_field & 16'h3FFF;
    else if (ty == hh4_pkg::TY_ACL) count = len_field;
    else count = len_field[7:0];
    send_byte({5'd0, ty});
    send_byte(code);
    if (ty != hh4_pkg::TY_EVT) send_byte(8'($urandom));
    send_byte(len_field[7:0]);
    if (ty == hh4_pkg::TY_ACL || ty == hh4_pkg::TY_ISO) send_byte(len_field[15:8]);
    for (int unsigned i = 0; i < count; i++) begin
      if (i < n_lead) send_byte(lead[23 - 8 * i -: 8]);
      else send_byte(8'($urandom));
    end
  endtask

  // Hold the stream until every owed item has come, then let the pipe settle
  task automatic wait_drained();
    int unsigned spin;
    spin = 0;
    push_off();
    while (h4_out_q.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    if (h4_out_q.size() != 0) begin
      $error("%0d expected result items never arrived", h4_out_q.size());
      errors++;
      h4_out_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_write(input logic [1:0] idx, input logic val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= hh4_pkg::APB_AW'({idx, 2'b00});
    pwdata <= hh4_pkg::APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic val);
    logic [hh4_pkg::APB_DW-1:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= hh4_pkg::APB_AW'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== hh4_pkg::APB_DW'(val)) begin
      $error("register %0d: expected %0h, got %0h", idx, hh4_pkg::APB_DW'(val), rd);
      errors++;
    end
  endtask

  // Write all three enables while idle, read them back, update the mirror
  task automatic set_config(input logic iso, input logic classic, input logic ext_adv);
    wait_drained();
    apb_write(hh4_pkg::REG_ISO_EN, iso);
    apb_write(hh4_pkg::REG_CLASSIC_EN, classic);
    apb_write(hh4_pkg::REG_EXT_ADV_EN, ext_adv);
    iso_en_m = iso;
    classic_en_m = classic;
    ext_adv_en_m = ext_adv;
    apb_check(hh4_pkg::REG_ISO_EN, iso);
    apb_check(hh4_pkg::REG_CLASSIC_EN, classic);
    apb_check(hh4_pkg::REG_EXT_ADV_EN, ext_adv);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Type bytes outside the known set, at both ends of the byte range
  task automatic test_bad_types();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h06);
    send_byte(8'h80);
    wait_drained();
  endtask

  // Header-only event, advertising report, short payload, classify misses
  task automatic test_event_frames();
    send_packet(hh4_pkg::TY_EVT, 16'd0, 8'h0E, 24'h0, 0);
    send_packet(hh4_pkg::TY_EVT, 16'd3, hh4_pkg::EVT_LE_META,
                {hh4_pkg::SUB_ADV_REPORT, 8'h01, 8'h00}, 3);
    send_packet(hh4_pkg::TY_EVT, 16'd1, hh4_pkg::EVT_LE_META,
                {hh4_pkg::SUB_EXT_ADV_REPORT, 16'h0}, 1);
    send_packet(hh4_pkg::TY_EVT, 16'd2, hh4_pkg::EVT_INQ_RESULT_RSSI, 24'h0, 0);
    send_packet(hh4_pkg::TY_EVT, 16'd3, hh4_pkg::EVT_LE_META,
                {hh4_pkg::SUB_EXT_ADV_REPORT, 8'h01, 8'h10}, 3);
    wait_drained();
  endtask

  // Command and SCO packets vanish; a following event proves sync is kept
  task automatic test_silent_frames();
    send_packet(hh4_pkg::TY_CMD, 16'd2, 8'h03, 24'h0, 0);
    send_packet(hh4_pkg::TY_SCO, 16'd0, 8'hFF, 24'h0, 0);
    send_packet(hh4_pkg::TY_SCO, 16'd3, 8'h00, 24'h0, 0);
    send_packet(hh4_pkg::TY_EVT, 16'd1, 8'h0F, 24'h0, 0);
    wait_drained();
  endtask

  // ACL and ISO, empty payloads, and ISO length bits above the low 14
  task automatic test_data_frames();
    send_packet(hh4_pkg::TY_ACL, 16'd0, 8'hFF, 24'h0, 0);
    send_packet(hh4_pkg::TY_ACL, 16'd3, 8'h00, 24'h0, 0);
    send_packet(hh4_pkg::TY_ISO, 16'hC002, 8'h7F, 24'h0, 0);
    send_packet(hh4_pkg::TY_ISO, 16'd0, 8'h80, 24'h0, 0);
    wait_drained();
  endtask

  // ISO off turns type 5 into a bad type; classic and legacy-report flags
  task automatic test_config_cases();
    set_config(1'b0, 1'b1, 1'b1);
    send_byte({5'd0, hh4_pkg::TY_ISO});
    send_packet(hh4_pkg::TY_EVT, 16'd2, hh4_pkg::EVT_INQ_RESULT_RSSI, 24'h0, 0);
    send_packet(hh4_pkg::TY_EVT, 16'd0, hh4_pkg::EVT_EXT_INQ_RESULT, 24'h0, 0);
    send_packet(hh4_pkg::TY_EVT, 16'd3, hh4_pkg::EVT_LE_META,
                {hh4_pkg::SUB_EXT_ADV_REPORT, 8'h01, 8'h10}, 3);
    send_packet(hh4_pkg::TY_EVT, 16'd3, hh4_pkg::EVT_LE_META,
                {hh4_pkg::SUB_EXT_ADV_REPORT, 8'h02, 8'h10}, 3);
    send_packet(hh4_pkg::TY_EVT, 16'd3, hh4_pkg::EVT_LE_META,
                {hh4_pkg::SUB_EXT_ADV_REPORT, 8'h01, 8'hEF}, 3);
    set_config(1'b1, 1'b0, 1'b0);
  endtask

  // Frame one byte over the limit: one oversize item, then its payload is
  // skipped; the stream ends a few bytes into that payload
  task automatic test_oversize_tail();
    logic [15:0] len;
    len = 16'(MAX_FIT_4HDR + 1);
    send_byte({5'd0, hh4_pkg::TY_ACL});
    send_byte(8'h22);
    send_byte(8'($urandom));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (4) send_byte(8'($urandom));
    wait_drained();
  endtask

  // Stop popping for a long stretch while the stream keeps coming
  task automatic test_backpressure();
    hold_req = HOLD_OFF_CYCLES;
    for (int i = 0; i < 6; i++) begin
      send_packet(hh4_pkg::TY_EVT, 16'd4, hh4_pkg::EVT_LE_META,
                  {hh4_pkg::SUB_ADV_REPORT, 16'h0}, 1);
    end
    wait_drained();
  endtask

  // Mostly well-formed packets with random content, some stray type bytes
  task automatic test_random_stream();
    int unsigned pick;
    int unsigned start;
    logic [2:0]  ty;
    logic [7:0]  code;
    logic [15:0] len;
    logic [23:0] lead;
    for (int unsigned phase_n = 0; phase_n < RANDOM_PHASES; phase_n++) begin
      if (phase_n == 0) set_config(1'b1, 1'b1, 1'b1);
      else if (phase_n == 1) set_config(1'b0, 1'b0, 1'b0);
      else set_config(1'($urandom), 1'($urandom), 1'($urandom));
      start = n_bytes;
      while (n_bytes - start < BYTES_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        lead = 24'($urandom);
        code = 8'($urandom);
        if (pick < 10) begin
          // Stray type byte; type 5 counts only while ISO is off
          if (!iso_en_m && $urandom_range(0, 2) == 0) send_byte({5'd0, hh4_pkg::TY_ISO});
          else if ($urandom_range(0, 4) == 0) send_byte(8'h00);
          else send_byte(8'($urandom_range(6, 255)));
        end else begin
          if (pick < 45) ty = hh4_pkg::TY_EVT;
          else if (pick < 70) ty = hh4_pkg::TY_ACL;
          else if (pick < 82) ty = iso_en_m ? hh4_pkg::TY_ISO : hh4_pkg::TY_ACL;
          else if (pick < 91) ty = hh4_pkg::TY_CMD;
          else ty = hh4_pkg::TY_SCO;
          len = 16'($urandom_range(0, (ty == hh4_pkg::TY_EVT) ? 12 : 16));
          if (ty == hh4_pkg::TY_ISO) len[15:14] = 2'($urandom);
          if (ty == hh4_pkg::TY_EVT) begin
            case ($urandom_range(0, 5))
              0, 1, 2: code = hh4_pkg::EVT_LE_META;
              3: code = hh4_pkg::EVT_INQ_RESULT_RSSI;
              4: code = hh4_pkg::EVT_EXT_INQ_RESULT;
              default: ;
            endcase
            // Bias the lead bytes toward the report shapes that classify
            if ($urandom_range(0, 1)) lead[23:16] = hh4_pkg::SUB_ADV_REPORT;
            else if ($urandom_range(0, 1)) lead[23:16] = hh4_pkg::SUB_EXT_ADV_REPORT;
            if ($urandom_range(0, 1)) lead[15:8] = 8'h01;
          end
          send_packet(ty, len, code, lead, 3);
        end
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_types();
    test_event_frames();
    test_silent_frames();
    test_data_frames();
    test_config_cases();
    test_backpressure();
    test_random_stream();
    test_oversize_tail();
    $display("Covered %0d stream bytes and %0d result items: %0d bad type, %0d oversize,",
             n_bytes, n_results, n_bad_type, n_oversize);
    $display("%0d droppable events, %0d input stall cycles, %0d register settings",
             n_droppable, n_full_stalls, n_settings);
    if (errors == 0) begin
      $display("hci_h4_stream_deframer test passed");
    end else begin
      $display("hci_h4_stream_deframer test failed");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #2000000;
    $display("hci_h4_stream_deframer test failed");
    $finish;
  end

endmodule
